FILE: hw/rtl/pcs_pkg.sv
`timescale 1ns / 1ps

package pcs_pkg;

   // widths of the configuration port and registers
   localparam int CFG_WIDTH     = 16;
   localparam int COUNT_WIDTH   = 8;
   localparam int CSR_IDX_WIDTH = 3;

   // default timer width
   localparam int TIMER_WIDTH_DEFAULT = 16;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TRANSITION_TICKS = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_AMBER_TICKS      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HOLD_TICKS       = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FLASH_TICKS      = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FLASH_CYCLES     = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BUZZ_ON_TICKS    = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BUZZ_OFF_TICKS   = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BUZZ_BURSTS      = 3'd7;

   // register reset values
   localparam logic [CFG_WIDTH-1:0]   TRANSITION_TICKS_RESET = 16'd750;
   localparam logic [CFG_WIDTH-1:0]   AMBER_TICKS_RESET      = 16'd2000;
   localparam logic [CFG_WIDTH-1:0]   HOLD_TICKS_RESET       = 16'd10000;
   localparam logic [CFG_WIDTH-1:0]   FLASH_TICKS_RESET      = 16'd500;
   localparam logic [COUNT_WIDTH-1:0] FLASH_CYCLES_RESET     = 8'd10;
   localparam logic [CFG_WIDTH-1:0]   BUZZ_ON_TICKS_RESET    = 16'd20;
   localparam logic [CFG_WIDTH-1:0]   BUZZ_OFF_TICKS_RESET   = 16'd100;
   localparam logic [COUNT_WIDTH-1:0] BUZZ_BURSTS_RESET      = 8'd100;

   // crossing sequence phases
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_GAP1,
      PH_AMBER,
      PH_GAP2,
      PH_GAP3,
      PH_GAP4,
      PH_WALK,
      PH_BUZZ_ON,
      PH_BUZZ_OFF,
      PH_FLASH_OFF,
      PH_FLASH_ON,
      PH_END_A,
      PH_END_B,
      PH_HOLD
   } phase_type;

   // lamp and buzzer drive
   typedef struct packed {
      logic buzzer;
      logic wait_lamp;
      logic stop_lamp;
      logic walk_lamp;
      logic traffic_red;
      logic traffic_amber;
      logic traffic_green;
   } lamps_type;

   localparam lamps_type LAMPS_RESET = '{
      buzzer:        1'b0,
      wait_lamp:     1'b0,
      stop_lamp:     1'b1,
      walk_lamp:     1'b0,
      traffic_red:   1'b0,
      traffic_amber: 1'b0,
      traffic_green: 1'b1
   };

endpackage

FILE: hw/rtl/pcs_req_if.sv
`timescale 1ns / 1ps

// tick item carrying the button level
interface pcs_req_if;
   logic valid;
   logic ready;
   logic button;

   modport source (output valid, output button, input ready);
   modport sink   (input valid, input button, output ready);
endinterface

FILE: hw/rtl/pcs_rsp_if.sv
`timescale 1ns / 1ps

// lamp state item, one per tick
interface pcs_rsp_if;
   logic valid;
   logic ready;
   logic traffic_green;
   logic traffic_amber;
   logic traffic_red;
   logic walk_lamp;
   logic stop_lamp;
   logic wait_lamp;
   logic buzzer;

   modport source (
      output valid, output traffic_green, output traffic_amber, output traffic_red,
      output walk_lamp, output stop_lamp, output wait_lamp, output buzzer,
      input ready
   );
   modport sink (
      input valid, input traffic_green, input traffic_amber, input traffic_red,
      input walk_lamp, input stop_lamp, input wait_lamp, input buzzer,
      output ready
   );
endinterface

FILE: hw/rtl/pedestrian_crossing_sequencer_core.sv
`timescale 1ns / 1ps
// path: an accepted tick item reaches its lamp item through the input register and the result register
// throughput: one tick item per cycle while the result channel is not stalled; the phase/timer update sets the pace
// a new item is taken while a finished result still waits, held by the result register
// reset (synchronous, active high): idle phase, traffic green and red man lit, timers cleared,
// all configuration registers back to their default durations and counts

module pedestrian_crossing_sequencer_core
   import pcs_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   pcs_req_if.sink                  req_chan,
   pcs_rsp_if.source                rsp_chan,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_write_data
);

   localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   // configuration registers
   logic [CFG_WIDTH-1:0]   transition_ticks_ff;
   logic [CFG_WIDTH-1:0]   amber_ticks_ff;
   logic [CFG_WIDTH-1:0]   hold_ticks_ff;
   logic [CFG_WIDTH-1:0]   flash_ticks_ff;
   logic [COUNT_WIDTH-1:0] flash_cycles_ff;
   logic [CFG_WIDTH-1:0]   buzz_on_ticks_ff;
   logic [CFG_WIDTH-1:0]   buzz_off_ticks_ff;
   logic [COUNT_WIDTH-1:0] buzz_bursts_ff;

   // input register
   logic item_valid_ff, item_valid_in;
   logic button_ff;

   // sequencer state
   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] repeat_ff, repeat_in;
   logic                   request_ff, request_in;
   logic                   wait_allowed_ff, wait_allowed_in;
   logic                   pressed_ff, pressed_in;

   // result register: lamp state doubles as the output payload
   lamps_type lamps_ff, lamps_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic                   compute;
   logic                   release_now;
   logic                   request_mid;
   logic                   start_now;
   logic                   finish;
   logic [CFG_WIDTH-1:0]   phase_len;
   logic [CMP_WIDTH-1:0]   len_ext;
   logic [CMP_WIDTH-1:0]   len_clip;
   logic [TIMER_WIDTH-1:0] tick_inc;
   logic [COUNT_WIDTH-1:0] repeat_next;
   logic                   bursts_done;
   logic                   flashes_done;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         transition_ticks_ff <= TRANSITION_TICKS_RESET;
         amber_ticks_ff      <= AMBER_TICKS_RESET;
         hold_ticks_ff       <= HOLD_TICKS_RESET;
         flash_ticks_ff      <= FLASH_TICKS_RESET;
         flash_cycles_ff     <= FLASH_CYCLES_RESET;
         buzz_on_ticks_ff    <= BUZZ_ON_TICKS_RESET;
         buzz_off_ticks_ff   <= BUZZ_OFF_TICKS_RESET;
         buzz_bursts_ff      <= BUZZ_BURSTS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TRANSITION_TICKS: transition_ticks_ff <= csr_write_data;
            CSR_AMBER_TICKS:      amber_ticks_ff      <= csr_write_data;
            CSR_HOLD_TICKS:       hold_ticks_ff       <= csr_write_data;
            CSR_FLASH_TICKS:      flash_ticks_ff      <= csr_write_data;
            CSR_FLASH_CYCLES:     flash_cycles_ff     <= csr_write_data[COUNT_WIDTH-1:0];
            CSR_BUZZ_ON_TICKS:    buzz_on_ticks_ff    <= csr_write_data;
            CSR_BUZZ_OFF_TICKS:   buzz_off_ticks_ff   <= csr_write_data;
            CSR_BUZZ_BURSTS:      buzz_bursts_ff      <= csr_write_data[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake and pipeline advance
   assign compute        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || compute;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         item_valid_in = 1'b1;
      end else if (compute) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (compute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // duration of the current phase
   always_comb begin
      case (phase_ff)
         PH_GAP1, PH_GAP2, PH_GAP3, PH_GAP4:             phase_len = transition_ticks_ff;
         PH_AMBER, PH_WALK:                              phase_len = amber_ticks_ff;
         PH_BUZZ_ON:                                     phase_len = buzz_on_ticks_ff;
         PH_BUZZ_OFF:                                    phase_len = buzz_off_ticks_ff;
         PH_FLASH_OFF, PH_FLASH_ON, PH_END_A, PH_END_B:  phase_len = flash_ticks_ff;
         PH_HOLD:                                        phase_len = hold_ticks_ff;
         default:                                        phase_len = '0;
      endcase
   end

   // saturating timer and phase end compare
   assign len_ext     = CMP_WIDTH'(phase_len);
   assign len_clip    = (len_ext > CMP_WIDTH'(TIMER_MAX)) ? CMP_WIDTH'(TIMER_MAX) : len_ext;
   assign tick_inc    = (tick_ff == TIMER_MAX) ? tick_ff : tick_ff + TIMER_WIDTH'(1);
   assign finish      = (CMP_WIDTH'(tick_inc) >= len_clip);

   // burst and flash counting
   assign repeat_next  = repeat_ff + COUNT_WIDTH'(1);
   assign bursts_done  = (repeat_next >= buzz_bursts_ff) || (repeat_next == '0);
   assign flashes_done = (repeat_next >= flash_cycles_ff) || (repeat_next == '0);

   // button release and request
   assign release_now = !button_ff && pressed_ff;
   assign request_mid = request_ff || release_now;
   assign start_now   = (phase_ff == PH_IDLE) && request_mid;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      tick_in         = tick_ff;
      repeat_in       = repeat_ff;
      request_in      = request_ff;
      wait_allowed_in = wait_allowed_ff;
      pressed_in      = pressed_ff;
      if (compute) begin
         if (button_ff) begin
            pressed_in = 1'b1;
         end else begin
            pressed_in = 1'b0;
            request_in = request_mid;
            if (phase_ff == PH_IDLE) begin
               if (start_now) begin
                  request_in = 1'b0;
                  phase_in   = PH_GAP1;
                  tick_in    = '0;
               end
            end else if (!finish) begin
               tick_in = tick_inc;
            end else begin
               tick_in = '0;
               case (phase_ff)
                  PH_GAP1:  phase_in = PH_AMBER;
                  PH_AMBER: phase_in = PH_GAP2;
                  PH_GAP2:  phase_in = PH_GAP3;
                  PH_GAP3: begin
                     wait_allowed_in = 1'b0;
                     phase_in        = PH_GAP4;
                  end
                  PH_GAP4:  phase_in = PH_WALK;
                  PH_WALK: begin
                     repeat_in = '0;
                     phase_in  = PH_BUZZ_ON;
                  end
                  PH_BUZZ_ON: phase_in = PH_BUZZ_OFF;
                  PH_BUZZ_OFF: begin
                     if (bursts_done) begin
                        repeat_in = '0;
                        phase_in  = PH_FLASH_OFF;
                     end else begin
                        repeat_in = repeat_next;
                        phase_in  = PH_BUZZ_ON;
                     end
                  end
                  PH_FLASH_OFF: phase_in = PH_FLASH_ON;
                  PH_FLASH_ON: begin
                     if (flashes_done) begin
                        repeat_in = '0;
                        phase_in  = PH_END_A;
                     end else begin
                        repeat_in = repeat_next;
                        phase_in  = PH_FLASH_OFF;
                     end
                  end
                  PH_END_A: phase_in = PH_END_B;
                  PH_END_B: begin
                     wait_allowed_in = 1'b1;
                     phase_in        = PH_HOLD;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
   end

   // lamp outputs
   always_comb begin
      lamps_in = lamps_ff;
      if (compute && !button_ff) begin
         if (release_now && wait_allowed_ff) begin
            lamps_in.wait_lamp = 1'b1;
         end
         if (phase_ff == PH_IDLE) begin
            if (start_now) begin
               lamps_in.traffic_green = 1'b0;
            end
         end else if (finish) begin
            case (phase_ff)
               PH_GAP1:  lamps_in.traffic_amber = 1'b1;
               PH_AMBER: lamps_in.traffic_amber = 1'b0;
               PH_GAP2:  lamps_in.traffic_red   = 1'b1;
               PH_GAP3: begin
                  lamps_in.wait_lamp = 1'b0;
                  lamps_in.stop_lamp = 1'b0;
               end
               PH_GAP4:    lamps_in.walk_lamp = 1'b1;
               PH_WALK:    lamps_in.buzzer    = 1'b1;
               PH_BUZZ_ON: lamps_in.buzzer    = 1'b0;
               PH_BUZZ_OFF: begin
                  if (bursts_done) begin
                     lamps_in.traffic_red   = 1'b0;
                     lamps_in.traffic_amber = 1'b0;
                     lamps_in.walk_lamp     = 1'b0;
                  end else begin
                     lamps_in.buzzer = 1'b1;
                  end
               end
               PH_FLASH_OFF: begin
                  lamps_in.walk_lamp     = 1'b1;
                  lamps_in.traffic_amber = 1'b1;
               end
               PH_FLASH_ON: begin
                  lamps_in.walk_lamp = 1'b0;
                  if (flashes_done) begin
                     lamps_in.stop_lamp = 1'b1;
                  end else begin
                     lamps_in.traffic_amber = 1'b0;
                  end
               end
               PH_END_A: lamps_in.traffic_amber = 1'b1;
               PH_END_B: begin
                  lamps_in.traffic_amber = 1'b0;
                  lamps_in.traffic_green = 1'b1;
                  lamps_in.stop_lamp     = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         tick_ff         <= '0;
         repeat_ff       <= '0;
         request_ff      <= 1'b0;
         wait_allowed_ff <= 1'b1;
         pressed_ff      <= 1'b0;
         lamps_ff        <= LAMPS_RESET;
      end else begin
         item_valid_ff   <= item_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         tick_ff         <= tick_in;
         repeat_ff       <= repeat_in;
         request_ff      <= request_in;
         wait_allowed_ff <= wait_allowed_in;
         pressed_ff      <= pressed_in;
         lamps_ff        <= lamps_in;
      end
   end

   // item payload register
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         button_ff <= req_chan.button;
      end
   end

   // result channel
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.traffic_green = lamps_ff.traffic_green;
   assign rsp_chan.traffic_amber = lamps_ff.traffic_amber;
   assign rsp_chan.traffic_red   = lamps_ff.traffic_red;
   assign rsp_chan.walk_lamp     = lamps_ff.walk_lamp;
   assign rsp_chan.stop_lamp     = lamps_ff.stop_lamp;
   assign rsp_chan.wait_lamp     = lamps_ff.wait_lamp;
   assign rsp_chan.buzzer        = lamps_ff.buzzer;

   // green man never shows against green traffic
   assert property (@(posedge clock) disable iff (reset)
      !(lamps_ff.walk_lamp && lamps_ff.traffic_green))
      else $error("walk lamp lit with traffic green");

   // buzzer sounds only inside a burst
   assert property (@(posedge clock) disable iff (reset)
      lamps_ff.buzzer |-> (phase_ff == PH_BUZZ_ON))
      else $error("buzzer on outside a burst phase");

   // idle keeps the timer cleared
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("timer running in idle");

   // a stalled result leaves the sequencer frozen
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("sequencer moved while result stalled");

endmodule

FILE: sim/pedestrian_crossing_sequencer_core_tb.sv
`timescale 1ns / 1ps

module pedestrian_crossing_sequencer_core_tb;
   import pcs_pkg::*;

   localparam int TIMER_WIDTH     = TIMER_WIDTH_DEFAULT;
   localparam int NUM_PHASES      = 14;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PRESSURE_AT     = 400;
   localparam int PRESSURE_CYCLES = 200;
   localparam int NUM_DIRECTED    = 14;
   // idle, press held, release starts the crossing, press during the gap freezes it,
   // second release latches a request, quick press and release
   localparam bit [0:NUM_DIRECTED-1] DIRECTED_LEVELS = 14'b00111000110100;

   // tracks the lamp state the crossing should show after each tick
   class lamp_sequence_tracker;
      phase_type              phase;
      longint                 tick_count;
      logic [COUNT_WIDTH-1:0] repeat_count;
      bit                     request_latched;
      bit                     wait_allowed;
      bit                     button_was_pressed;
      lamps_type              lamps;
      logic [CFG_WIDTH-1:0]   transition_ticks, amber_ticks, hold_ticks, flash_ticks;
      logic [CFG_WIDTH-1:0]   buzz_on_ticks, buzz_off_ticks;
      logic [COUNT_WIDTH-1:0] flash_cycles, buzz_bursts;
      longint                 timer_max;
      lamps_type              lamps_due[$];
      int                     mismatches;

      function new(int timer_width);
         timer_max  = (longint'(1) << timer_width) - 1;
         mismatches = 0;
         transition_ticks = TRANSITION_TICKS_RESET;
         amber_ticks      = AMBER_TICKS_RESET;
         hold_ticks       = HOLD_TICKS_RESET;
         flash_ticks      = FLASH_TICKS_RESET;
         flash_cycles     = FLASH_CYCLES_RESET;
         buzz_on_ticks    = BUZZ_ON_TICKS_RESET;
         buzz_off_ticks   = BUZZ_OFF_TICKS_RESET;
         buzz_bursts      = BUZZ_BURSTS_RESET;
         phase              = PH_IDLE;
         tick_count         = 0;
         repeat_count       = '0;
         request_latched    = 1'b0;
         wait_allowed       = 1'b1;
         button_was_pressed = 1'b0;
         lamps              = LAMPS_RESET;
      endfunction

      function void set_register(logic [CSR_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
         case (idx)
            CSR_TRANSITION_TICKS: transition_ticks = data;
            CSR_AMBER_TICKS:      amber_ticks      = data;
            CSR_HOLD_TICKS:       hold_ticks       = data;
            CSR_FLASH_TICKS:      flash_ticks      = data;
            CSR_FLASH_CYCLES:     flash_cycles     = data[COUNT_WIDTH-1:0];
            CSR_BUZZ_ON_TICKS:    buzz_on_ticks    = data;
            CSR_BUZZ_OFF_TICKS:   buzz_off_ticks   = data;
            CSR_BUZZ_BURSTS:      buzz_bursts      = data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // length of the current phase in ticks
      function longint phase_span();
         case (phase)
            PH_GAP1, PH_GAP2, PH_GAP3, PH_GAP4:  return longint'(transition_ticks);
            PH_AMBER, PH_WALK:                   return longint'(amber_ticks);
            PH_BUZZ_ON:                          return longint'(buzz_on_ticks);
            PH_BUZZ_OFF:                         return longint'(buzz_off_ticks);
            PH_FLASH_OFF, PH_FLASH_ON, PH_END_A, PH_END_B:
                                                 return longint'(flash_ticks);
            PH_HOLD:                             return longint'(hold_ticks);
            default:                             return longint'(0);
         endcase
      endfunction

      function void enter_phase(phase_type nxt);
         phase      = nxt;
         tick_count = 0;
      endfunction

      // lamp changes at the end of each phase
      function void close_phase();
         case (phase)
            PH_GAP1: begin
               lamps.traffic_amber = 1'b1;
               enter_phase(PH_AMBER);
            end
            PH_AMBER: begin
               lamps.traffic_amber = 1'b0;
               enter_phase(PH_GAP2);
            end
            PH_GAP2: begin
               lamps.traffic_red = 1'b1;
               enter_phase(PH_GAP3);
            end
            PH_GAP3: begin
               wait_allowed    = 1'b0;
               lamps.wait_lamp = 1'b0;
               lamps.stop_lamp = 1'b0;
               enter_phase(PH_GAP4);
            end
            PH_GAP4: begin
               lamps.walk_lamp = 1'b1;
               enter_phase(PH_WALK);
            end
            PH_WALK: begin
               lamps.buzzer = 1'b1;
               repeat_count = '0;
               enter_phase(PH_BUZZ_ON);
            end
            PH_BUZZ_ON: begin
               lamps.buzzer = 1'b0;
               enter_phase(PH_BUZZ_OFF);
            end
            PH_BUZZ_OFF: begin
               repeat_count = repeat_count + COUNT_WIDTH'(1);
               if (repeat_count >= buzz_bursts || repeat_count == 0) begin
                  repeat_count        = '0;
                  lamps.traffic_red   = 1'b0;
                  lamps.traffic_amber = 1'b0;
                  lamps.walk_lamp     = 1'b0;
                  enter_phase(PH_FLASH_OFF);
               end else begin
                  lamps.buzzer = 1'b1;
                  enter_phase(PH_BUZZ_ON);
               end
            end
            PH_FLASH_OFF: begin
               lamps.walk_lamp     = 1'b1;
               lamps.traffic_amber = 1'b1;
               enter_phase(PH_FLASH_ON);
            end
            PH_FLASH_ON: begin
               repeat_count = repeat_count + COUNT_WIDTH'(1);
               if (repeat_count >= flash_cycles || repeat_count == 0) begin
                  repeat_count    = '0;
                  lamps.walk_lamp = 1'b0;
                  lamps.stop_lamp = 1'b1;
                  enter_phase(PH_END_A);
               end else begin
                  lamps.walk_lamp     = 1'b0;
                  lamps.traffic_amber = 1'b0;
                  enter_phase(PH_FLASH_OFF);
               end
            end
            PH_END_A: begin
               lamps.traffic_amber = 1'b1;
               enter_phase(PH_END_B);
            end
            PH_END_B: begin
               lamps.traffic_amber = 1'b0;
               wait_allowed        = 1'b1;
               lamps.traffic_green = 1'b1;
               lamps.stop_lamp     = 1'b1;
               enter_phase(PH_HOLD);
            end
            default: enter_phase(PH_IDLE);
         endcase
      endfunction

      // one accepted tick item: update the crossing and queue the lamps it shows
      function void note_tick(logic pressed);
         longint span;
         if (pressed) begin
            button_was_pressed = 1'b1;
         end else begin
            if (button_was_pressed) begin
               button_was_pressed = 1'b0;
               if (wait_allowed)
                  lamps.wait_lamp = 1'b1;
               request_latched = 1'b1;
            end
            if (phase == PH_IDLE) begin
               if (request_latched) begin
                  request_latched     = 1'b0;
                  lamps.traffic_green = 1'b0;
                  enter_phase(PH_GAP1);
               end
            end else begin
               span = phase_span();
               if (span > timer_max)
                  span = timer_max;
               if (tick_count < timer_max)
                  tick_count = tick_count + 1;
               if (tick_count >= span)
                  close_phase();
            end
         end
         lamps_due.push_back(lamps);
      endfunction

      function void check_field(string name, logic want, logic seen);
         if (seen !== want) begin
            $error("%s: expected %0b, got %0b", name, want, seen);
            mismatches++;
         end
      endfunction

      // compare one lamp item with the oldest queued lamp state
      function void check_lamps(lamps_type seen);
         lamps_type want;
         if (lamps_due.size() == 0) begin
            $error("lamp item arrived with no tick waiting");
            mismatches++;
            return;
         end
         want = lamps_due.pop_front();
         check_field("traffic_green", want.traffic_green, seen.traffic_green);
         check_field("traffic_amber", want.traffic_amber, seen.traffic_amber);
         check_field("traffic_red", want.traffic_red, seen.traffic_red);
         check_field("walk_lamp", want.walk_lamp, seen.walk_lamp);
         check_field("stop_lamp", want.stop_lamp, seen.stop_lamp);
         check_field("wait_lamp", want.wait_lamp, seen.wait_lamp);
         check_field("buzzer", want.buzzer, seen.buzzer);
      endfunction

      function int pending();
         return lamps_due.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0]     csr_write_data;

   pcs_req_if req_chan ();
   pcs_rsp_if rsp_chan ();

   lamp_sequence_tracker tracker = new(TIMER_WIDTH);

   int cycle_count = 0;
   int lamps_received = 0;
   bit sender_gaps_on = 1'b1;
   bit receiver_stalls_on = 1'b1;
   int press_left = 0;
   int release_left = 0;
   int noise_left = 0;

   pedestrian_crossing_sequencer_core #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pedestrian_crossing_sequencer_core_tb: errors");
         $finish;
      end
   end

   function automatic int draw_gap();
      return sender_gaps_on ? $urandom_range(0, 12) : 0;
   endfunction

   // button level: mostly press then release runs, some random chatter
   function automatic logic next_level();
      if (press_left == 0 && release_left == 0 && noise_left == 0) begin
         if ($urandom_range(0, 9) < 7) begin
            press_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30)
                                                       : $urandom_range(1, 3);
            release_left = $urandom_range(0, 50);
         end else begin
            noise_left = $urandom_range(1, 8);
         end
      end
      if (noise_left > 0) begin
         noise_left--;
         return 1'($urandom_range(0, 1));
      end
      if (press_left > 0) begin
         press_left--;
         return 1'b1;
      end
      release_left--;
      return 1'b0;
   endfunction

   // durations per phase: all zero, all one, all max, then mostly short
   function automatic logic [CFG_WIDTH-1:0] pick_duration(input int p);
      case (p)
         0: return '0;
         1: return CFG_WIDTH'(1);
         2: return '1;
         3: return CFG_WIDTH'($urandom_range(0, 1));
         default: begin
            if ($urandom_range(0, 29) == 0)
               return CFG_WIDTH'($urandom);
            if ($urandom_range(0, 9) == 0)
               return CFG_WIDTH'($urandom_range(7, 40));
            return CFG_WIDTH'($urandom_range(0, 6));
         end
      endcase
   endfunction

   function automatic logic [CFG_WIDTH-1:0] pick_count(input int p);
      case (p)
         0: return '0;
         1: return CFG_WIDTH'(1);
         2, 3: return CFG_WIDTH'(255);
         default: begin
            if ($urandom_range(0, 14) == 0)
               return CFG_WIDTH'($urandom_range(0, 255));
            return CFG_WIDTH'($urandom_range(0, 4));
         end
      endcase
   endfunction

   function automatic int phase_items(input int p);
      case (p)
         0, 1:    return 120;
         2:       return 50;
         3:       return 500;
         default: return $urandom_range(80, 120);
      endcase
   endfunction

   task automatic send_tick(input logic level, input int gap);
      repeat (gap) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.button <= level;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_tick(level);
   endtask

   task automatic write_register(input logic [CSR_IDX_WIDTH-1:0] idx,
                                 input logic [CFG_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   // wait for every queued lamp item, then let the pipeline settle
   task automatic drain_lamps();
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // lamp receiver with random stalls and one long hold-off
   initial begin
      int        stall;
      lamps_type seen;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (lamps_received == PRESSURE_AT) begin
            rsp_chan.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         stall = receiver_stalls_on ? $urandom_range(0, 12) : 0;
         repeat (stall) begin
            rsp_chan.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         seen.traffic_green = rsp_chan.traffic_green;
         seen.traffic_amber = rsp_chan.traffic_amber;
         seen.traffic_red   = rsp_chan.traffic_red;
         seen.walk_lamp     = rsp_chan.walk_lamp;
         seen.stop_lamp     = rsp_chan.stop_lamp;
         seen.wait_lamp     = rsp_chan.wait_lamp;
         seen.buzzer        = rsp_chan.buzzer;
         tracker.check_lamps(seen);
         lamps_received++;
         if (lamps_received % 50 == 0)
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
      end
   end

   // stimulus
   initial begin
      int i;
      int p;
      int n;
      int target;
      int k;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.button  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed ticks under the reset durations
      for (i = 0; i < NUM_DIRECTED; i++)
         send_tick(DIRECTED_LEVELS[i], draw_gap());

      // configuration phases, each followed by a run of random ticks
      for (p = 0; p < NUM_PHASES; p++) begin
         drain_lamps();
         write_register(CSR_TRANSITION_TICKS, pick_duration(p));
         write_register(CSR_AMBER_TICKS, pick_duration(p));
         write_register(CSR_HOLD_TICKS, pick_duration(p));
         write_register(CSR_FLASH_TICKS, pick_duration(p));
         write_register(CSR_FLASH_CYCLES, pick_count(p));
         write_register(CSR_BUZZ_ON_TICKS, pick_duration(p));
         write_register(CSR_BUZZ_OFF_TICKS, pick_duration(p));
         write_register(CSR_BUZZ_BURSTS, pick_count(p));
         csr_write_enable <= 1'b0;
         // keep offering back to back while the receiver holds off
         sender_gaps_on = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         target = phase_items(p);
         for (n = 0; n < target; n++)
            send_tick(next_level(), draw_gap());
      end

      // final drain
      req_chan.valid <= 1'b0;
      for (k = 0; k < DRAIN_LIMIT && tracker.pending() != 0; k++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d lamp items never arrived", tracker.pending());
         tracker.mismatches++;
      end

      if (tracker.mismatches == 0)
         $display("pedestrian_crossing_sequencer_core_tb: clean");
      else
         $display("pedestrian_crossing_sequencer_core_tb: errors");
      $finish;
   end

endmodule
